FILE: hdl/bfr_pkg.sv
// Package for the bitstream field reader: item codes, status codes, defaults and states.
`default_nettype none
package bfr_pkg;
	localparam int BUF_BYTES_DEF = 2048;

	localparam logic [2:0] KIND_APPEND  = 3'd0;
	localparam logic [2:0] KIND_RESTART = 3'd1;
	localparam logic [2:0] KIND_FIXED   = 3'd2;
	localparam logic [2:0] KIND_UE      = 3'd3;
	localparam logic [2:0] KIND_NS      = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DRY  = 2'd1;
	localparam logic [1:0] ST_WIDE = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam int MAX_FIXED = 32;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREFIX,
		S_SUFFIX,
		S_FIELD,
		S_NSX,
		S_RESULT
	} state_t;
endpackage
`default_nettype wire

FILE: hdl/bfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bfr_pkg::BUF_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: hdl/bitstream_field_reader.sv
// Top level of the bitstream field reader: sequencer around the byte store.
// Usage: items arrive on in_valid/in_ready with kind, byte_value and amount.
// Kind 0 appends a byte, kind 1 restarts with an empty buffer, kind 2 reads
// a fixed field of amount bits, kind 3 reads an exp-Golomb ue(v) code and
// kind 4 reads an ns(n) value with n taken from amount. Every item returns
// exactly one result item on out_valid/out_ready: value, status, bits_left.
// Bits are taken one per cycle from the byte held in the RAM read register,
// except that each time a new byte is entered the RAM must be read first.
// Append, restart and reads rejected at acceptance go straight to the result
// state; the reads are a serial bit loop over the single RAM read port.
// After reset the buffer is empty and the read position is zero; the byte
// store itself is not cleared. A new item is accepted as soon as the engine
// is idle, even while the previous result still waits in the output
// register. When the receiver stalls, a finished result waits in its own
// state until the output register is free, and no new item is accepted.
`default_nettype none
module bitstream_field_reader #(
	parameter int BUF_BYTES = bfr_pkg::BUF_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  byte_value,
	input  wire logic [31:0] amount,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] value,
	output logic      [1:0]  status,
	output logic      [14:0] bits_left
);
	localparam int AW = $clog2(BUF_BYTES);
	localparam int PW = $clog2(BUF_BYTES * 8 + 1);

	bfr_pkg::state_t state_q, state_d;
	logic [PW-1:0] pos_q, pos_d, fill_q, fill_d;
	logic          bv_q, bv_d;          // RAM read register holds the byte at pos_q
	logic          ns_q, ns_d;          // fixed-width phase belongs to an ns read
	logic [31:0]   acc_q, acc_d;
	logic [31:0]   m_q, m_d;
	logic [5:0]    cnt_q, cnt_d;
	logic [4:0]    zeros_q, zeros_d;
	logic [31:0]   res_value_q, res_value_d;
	logic [1:0]    res_status_q, res_status_d;

	logic [PW-1:0] rem;
	logic [32:0]   rem33;
	logic [PW-1:0] pos_byte, fill_byte;
	logic          ram_we, ram_re;
	logic [7:0]    ram_rdata;
	logic          cur_bit;
	logic [5:0]    ns_w;
	logic [32:0]   ns_m;
	logic [32:0]   ns_val;
	logic          accept;

	assign rem       = fill_q - pos_q;
	assign rem33     = 33'(rem);
	assign pos_byte  = pos_q >> 3;
	assign fill_byte = fill_q >> 3;
	assign cur_bit   = ram_rdata[~pos_q[2:0]];
	assign in_ready  = (state_q == bfr_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;

	// Bit length of n and the count of short codewords for an ns read.
	always_comb begin
		ns_w = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (amount[i]) begin
				ns_w = 6'(i + 1);
			end
		end
		ns_m = (33'd1 << ns_w) - {1'b0, amount};
	end

	assign ns_val = {acc_q, 1'b0} - {1'b0, m_q} + {32'd0, cur_bit};

	bfr_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_byte[AW-1:0]),
		.wdata(byte_value),
		.rd_en(ram_re),
		.raddr(pos_byte[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bfr_pkg::S_IDLE;
			pos_q     <= '0;
			fill_q    <= '0;
			bv_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			fill_q  <= fill_d;
			bv_q    <= bv_d;
			if (state_q == bfr_pkg::S_RESULT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ns_q         <= ns_d;
		acc_q        <= acc_d;
		m_q          <= m_d;
		cnt_q        <= cnt_d;
		zeros_q      <= zeros_d;
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
		if (state_q == bfr_pkg::S_RESULT && (!out_valid || out_ready)) begin
			value     <= res_value_q;
			status    <= res_status_q;
			bits_left <= 15'(rem);
		end
	end

	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		fill_d       = fill_q;
		bv_d         = bv_q;
		ns_d         = ns_q;
		acc_d        = acc_q;
		m_d          = m_q;
		cnt_d        = cnt_q;
		zeros_d      = zeros_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;

		case (state_q)
			bfr_pkg::S_IDLE: begin
				if (accept) begin
					res_value_d  = 32'd0;
					res_status_d = bfr_pkg::ST_OK;
					bv_d         = 1'b0;
					acc_d        = 32'd0;
					state_d      = bfr_pkg::S_RESULT;
					case (kind)
						bfr_pkg::KIND_APPEND: begin
							if (fill_byte >= PW'(BUF_BYTES)) begin
								res_status_d = bfr_pkg::ST_FULL;
							end else begin
								ram_we = 1'b1;
								fill_d = fill_q + PW'(8);
							end
						end
						bfr_pkg::KIND_RESTART: begin
							pos_d  = '0;
							fill_d = '0;
						end
						bfr_pkg::KIND_FIXED: begin
							if (amount > 32'(bfr_pkg::MAX_FIXED)) begin
								res_status_d = bfr_pkg::ST_WIDE;
							end else if (rem33 < {1'b0, amount}) begin
								res_status_d = bfr_pkg::ST_DRY;
							end else begin
								cnt_d   = amount[5:0];
								ns_d    = 1'b0;
								state_d = bfr_pkg::S_FIELD;
							end
						end
						bfr_pkg::KIND_UE: begin
							zeros_d = 5'd0;
							state_d = bfr_pkg::S_PREFIX;
						end
						bfr_pkg::KIND_NS: begin
							if (amount == 32'd0) begin
								res_status_d = bfr_pkg::ST_WIDE;
							end else if (rem33 < 33'(ns_w - 6'd1)) begin
								res_status_d = bfr_pkg::ST_DRY;
							end else begin
								cnt_d   = ns_w - 6'd1;
								m_d     = ns_m[31:0];
								ns_d    = 1'b1;
								state_d = bfr_pkg::S_FIELD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			bfr_pkg::S_PREFIX: begin
				if (rem == '0) begin
					res_status_d = bfr_pkg::ST_DRY;
					state_d      = bfr_pkg::S_RESULT;
				end else if (!bv_q) begin
					ram_re = 1'b1;
					bv_d   = 1'b1;
				end else begin
					pos_d = pos_q + PW'(1);
					bv_d  = (pos_q[2:0] != 3'd7);
					if (cur_bit) begin
						cnt_d   = 6'(zeros_q);
						acc_d   = 32'd1;
						state_d = bfr_pkg::S_SUFFIX;
					end else if (zeros_q == 5'd31) begin
						res_status_d = bfr_pkg::ST_WIDE;
						state_d      = bfr_pkg::S_RESULT;
					end else begin
						zeros_d = zeros_q + 5'd1;
					end
				end
			end
			bfr_pkg::S_SUFFIX: begin
				if (cnt_q == 6'd0) begin
					res_value_d = acc_q - 32'd1;
					state_d     = bfr_pkg::S_RESULT;
				end else if (rem == '0) begin
					res_status_d = bfr_pkg::ST_DRY;
					state_d      = bfr_pkg::S_RESULT;
				end else if (!bv_q) begin
					ram_re = 1'b1;
					bv_d   = 1'b1;
				end else begin
					pos_d = pos_q + PW'(1);
					bv_d  = (pos_q[2:0] != 3'd7);
					acc_d = {acc_q[30:0], cur_bit};
					cnt_d = cnt_q - 6'd1;
				end
			end
			bfr_pkg::S_FIELD: begin
				// Bits were checked at acceptance; only the ns extra bit gets a dry test.
				if (cnt_q == 6'd0) begin
					if (!ns_q || acc_q < m_q) begin
						res_value_d = acc_q;
						state_d     = bfr_pkg::S_RESULT;
					end else if (rem == '0) begin
						res_status_d = bfr_pkg::ST_DRY;
						state_d      = bfr_pkg::S_RESULT;
					end else begin
						state_d = bfr_pkg::S_NSX;
					end
				end else if (!bv_q) begin
					ram_re = 1'b1;
					bv_d   = 1'b1;
				end else begin
					pos_d = pos_q + PW'(1);
					bv_d  = (pos_q[2:0] != 3'd7);
					acc_d = {acc_q[30:0], cur_bit};
					cnt_d = cnt_q - 6'd1;
				end
			end
			bfr_pkg::S_NSX: begin
				if (!bv_q) begin
					ram_re = 1'b1;
					bv_d   = 1'b1;
				end else begin
					pos_d       = pos_q + PW'(1);
					bv_d        = (pos_q[2:0] != 3'd7);
					res_value_d = ns_val[31:0];
					state_d     = bfr_pkg::S_RESULT;
				end
			end
			bfr_pkg::S_RESULT: begin
				if (!out_valid || out_ready) begin
					state_d = bfr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bfr_pkg::S_IDLE;
			end
		endcase
	end

	// The read position never passes the fill level.
	a_pos_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= fill_q)
		else $error("read position beyond fill level");

	// Any failed item reports a zero value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bfr_pkg::ST_OK |-> value == 32'd0)
		else $error("nonzero value on failure");

	// An accepted item keeps the engine busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while engine busy");
endmodule
`default_nettype wire

FILE: dv/tb_bitstream_field_reader.sv
// Testbench for the bitstream field reader: random and directed items checked against a predictor.
`default_nettype none
module tb_bitstream_field_reader;
	localparam int NBYTES = bfr_pkg::BUF_BYTES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	// Scoreboard: holds the predicted bit reader state and the queue of expected results.
	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [14:0] bits_left;
	} reader_result_t;

	class reader_scoreboard;
		logic [7:0] store_bytes [NBYTES];
		int unsigned rd_pos;
		int unsigned fill;
		reader_result_t pending[$];
		int errors;

		function new();
			rd_pos = 0;
			fill = 0;
			errors = 0;
		endfunction

		function int unsigned remaining();
			return (fill > rd_pos) ? fill - rd_pos : 0;
		endfunction

		function logic next_bit();
			logic b;
			b = store_bytes[rd_pos >> 3][7 - (rd_pos & 7)];
			rd_pos++;
			return b;
		endfunction

		function logic [1:0] ue_read(output logic [31:0] v);
			int unsigned zeros;
			logic [32:0] info;
			v = 0;
			zeros = 0;
			forever begin
				if (remaining() < 1) return bfr_pkg::ST_DRY;
				if (next_bit()) break;
				zeros++;
				if (zeros > 31) return bfr_pkg::ST_WIDE;
			end
			info = 33'd1 << zeros;
			for (int i = zeros; i > 0; i--) begin
				if (remaining() < 1) return bfr_pkg::ST_DRY;
				info[i-1] = next_bit();
			end
			v = 32'(info - 33'd1);
			return bfr_pkg::ST_OK;
		endfunction

		function logic [1:0] ns_read(logic [31:0] n, output logic [31:0] v);
			int unsigned w;
			logic [32:0] m;
			logic [32:0] x;
			v = 0;
			if (n == 0) return bfr_pkg::ST_WIDE;
			w = 0;
			for (int i = 0; i < 32; i++) if (n[i]) w = i + 1;
			m = (33'd1 << w) - {1'b0, n};
			if (remaining() < w - 1) return bfr_pkg::ST_DRY;
			x = 0;
			for (int i = 0; i < w - 1; i++) x = {x[31:0], next_bit()};
			if (x < m) begin
				v = x[31:0];
				return bfr_pkg::ST_OK;
			end
			if (remaining() < 1) return bfr_pkg::ST_DRY;
			x = {x[31:0], next_bit()} - m;
			v = x[31:0];
			return bfr_pkg::ST_OK;
		endfunction

		// Note an accepted input item and queue the result it must produce.
		function void note_item(logic [2:0] k, logic [7:0] b, logic [31:0] amt);
			reader_result_t r;
			logic [31:0] v;
			r.value = 0;
			r.status = bfr_pkg::ST_OK;
			v = 0;
			case (k)
				bfr_pkg::KIND_APPEND: begin
					if ((fill >> 3) >= NBYTES) r.status = bfr_pkg::ST_FULL;
					else begin
						store_bytes[fill >> 3] = b;
						fill += 8;
					end
				end
				bfr_pkg::KIND_RESTART: begin
					rd_pos = 0;
					fill = 0;
				end
				bfr_pkg::KIND_FIXED: begin
					if (amt > bfr_pkg::MAX_FIXED) r.status = bfr_pkg::ST_WIDE;
					else if (remaining() < amt) r.status = bfr_pkg::ST_DRY;
					else begin
						for (int i = 0; i < amt; i++) v = {v[30:0], next_bit()};
						r.value = v;
					end
				end
				bfr_pkg::KIND_UE: begin
					r.status = ue_read(v);
					r.value = v;
				end
				bfr_pkg::KIND_NS: begin
					r.status = ns_read(amt, v);
					r.value = v;
				end
				default: ;
			endcase
			if (r.status != bfr_pkg::ST_OK) r.value = 0;
			r.bits_left = 15'(remaining());
			pending.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
			errors++;
		endtask

		// Compare one accepted result item with the oldest expectation.
		task check_result(logic [31:0] v, logic [1:0] s, logic [14:0] bl);
			reader_result_t e;
			if (pending.size() == 0) begin
				report("unexpected result", v, 0);
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) report("value", v, e.value);
			if (s !== e.status) report("status", 32'(s), 32'(e.status));
			if (bl !== e.bits_left) report("bits_left", 32'(bl), 32'(e.bits_left));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] kind;
	logic [7:0] byte_value;
	logic [31:0] amount;
	logic out_valid;
	logic out_ready;
	logic [31:0] value;
	logic [1:0] status;
	logic [14:0] bits_left;

	reader_scoreboard sb;
	int idle_cycles;
	bit stall_on;

	bitstream_field_reader DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .byte_value(byte_value), .amount(amount),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status), .bits_left(bits_left)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Receiver: accepted results go to the scoreboard; ready follows its own
	// stall pattern, with long stretches where it never stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(value, status, bits_left);
			if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
			out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// Watchdog: counts cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_bitstream_field_reader failed");
			$finish;
		end
	end

	// Present one item and hold it until accepted; the predictor sees it at
	// the accepting edge. Valid stays high into the next item when no gap follows.
	task automatic send_item(logic [2:0] k, logic [7:0] b, logic [31:0] amt, int gap);
		in_valid <= 1'b1;
		kind <= k;
		byte_value <= b;
		amount <= amt;
		do @(posedge clk); while (!in_ready);
		sb.note_item(k, b, amt);
		if (gap > 0) begin
			in_valid <= 1'b0;
			kind <= 3'($urandom);
			byte_value <= 8'($urandom);
			amount <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	int burst_left;

	// Gap before the next item: bursts of random length with random gaps between.
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(0, 30);
		return $urandom_range(1, 12);
	endfunction

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'(33 + $urandom_range(0, 5));
			2: return 32'd32;
			3: return 32'd0;
			default: return 32'($urandom_range(1, 31));
		endcase
	endfunction

	initial begin
		int k;
		sb = new();
		in_valid = 0;
		kind = 0;
		byte_value = 0;
		amount = 0;
		out_ready = 1;
		stall_on = 0;
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: reads on an empty buffer, extreme bytes, each kind.
		send_item(bfr_pkg::KIND_FIXED, 8'h00, 32'd1, 0);
		send_item(bfr_pkg::KIND_UE, 8'h00, 32'd0, 0);
		send_item(bfr_pkg::KIND_NS, 8'h00, 32'd0, 1);
		send_item(bfr_pkg::KIND_NS, 8'h00, 32'd5, 0);
		send_item(bfr_pkg::KIND_FIXED, 8'h00, 32'hFFFF_FFFF, 0);
		send_item(bfr_pkg::KIND_FIXED, 8'h00, 32'd0, 0);
		send_item(3'd5, 8'hFF, 32'd7, 0);
		send_item(3'd7, 8'h00, 32'd0, 2);
		for (int i = 0; i < 5; i++) send_item(bfr_pkg::KIND_APPEND, 8'hFF, 32'd0, 0);
		send_item(bfr_pkg::KIND_FIXED, 8'h00, 32'd32, 0);
		send_item(bfr_pkg::KIND_FIXED, 8'h00, 32'd9, 0);
		send_item(bfr_pkg::KIND_FIXED, 8'h00, 32'd8, 0);
		send_item(bfr_pkg::KIND_RESTART, 8'h00, 32'd0, 0);
		// A long zero prefix: the 32nd leading zero ends the ue read as too wide.
		for (int i = 0; i < 5; i++) send_item(bfr_pkg::KIND_APPEND, 8'h00, 32'd0, 0);
		send_item(bfr_pkg::KIND_UE, 8'h00, 32'd0, 0);
		send_item(bfr_pkg::KIND_UE, 8'h00, 32'd0, 0);
		send_item(bfr_pkg::KIND_APPEND, 8'h01, 32'd0, 0);
		send_item(bfr_pkg::KIND_NS, 8'h00, 32'hFFFF_FFFF, 3);
		send_item(bfr_pkg::KIND_RESTART, 8'h00, 32'd0, 0);

		// Random part: reads mixed with appends, with restarts and noise.
		for (int n = 0; n < 1320; n++) begin
			k = $urandom_range(0, 99);
			if (k < 35) begin
				send_item(bfr_pkg::KIND_APPEND, 8'($urandom), $urandom, next_gap());
			end else if (k < 37) begin
				send_item(bfr_pkg::KIND_RESTART, 8'($urandom), $urandom, next_gap());
			end else if (k < 57) begin
				send_item(bfr_pkg::KIND_FIXED, 8'($urandom), rand_amount(), next_gap());
			end else if (k < 77) begin
				send_item(bfr_pkg::KIND_UE, 8'($urandom), $urandom, next_gap());
			end else if (k < 97) begin
				send_item(bfr_pkg::KIND_NS, 8'($urandom), rand_amount(), next_gap());
			end else begin
				send_item(3'($urandom_range(5, 7)), 8'($urandom), $urandom, next_gap());
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_bitstream_field_reader passed");
		end else begin
			$display("tb_bitstream_field_reader failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: bitstream_field_reader.f
hdl/bfr_pkg.sv
hdl/bfr_ram.sv
hdl/bitstream_field_reader.sv
dv/tb_bitstream_field_reader.sv
